// ===== hdl/sorted_set_insert_delete_unit_assert.svh =====
// Assertion macros for the sorted set unit.
// Both expect clk and arst_n in the scope of the module that uses them.
`ifndef SORTED_SET_INSERT_DELETE_UNIT_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SSID_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSID_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ssid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssid_pkg;

	localparam int DATA_W = 32;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIX,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic fix;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic emit_done;
	} status_t;

endpackage

`default_nettype wire

// ===== hdl/ssid_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/ssid_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssid_ctrl import ssid_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/ssid_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssid_datapath import ssid_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output status_t                       status,
	input  wire logic                     kind,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      element,
	output logic                          set_empty,
	output logic                          last,
	output logic                          dropped
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// control state
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_idx_q;
	logic          pend_q;
	logic          found_q;
	logic          placed_q;
	logic          dropped_q;
	logic          out_v_q;
	logic          skid_v_q;

	// payload
	logic                     kind_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] carry_q;
	logic [AW-1:0]            pidx_q;
	logic                     pend_last_q;
	logic                     pend_empty_q;
	logic signed [DATA_W-1:0] out_elem_q;
	logic                     out_last_q;
	logic signed [DATA_W-1:0] skid_elem_q;
	logic                     skid_last_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic signed [DATA_W-1:0] rd_val;

	logic          ins;
	logic          full;
	logic [CW-1:0] nwords;
	logic [1:0]    occ;
	logic          acc;
	logic          scan_issue;
	logic          emit_issue;
	logic          issue;
	logic          scan_data;
	logic          hit;
	logic          gt;
	logic          shift_in;
	logic          land;
	logic signed [DATA_W-1:0] land_elem;

	ssid_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_val = $signed(ram_rdata);
	assign ins    = (kind_q == KIND_INSERT);
	assign full   = (cnt_q == CAP_C);
	assign nwords = (cnt_q == '0) ? CW'(1) : cnt_q;
	assign acc    = out_v_q & out_ready;
	assign occ    = {1'b0, out_v_q} + {1'b0, skid_v_q} + {1'b0, pend_q} - {1'b0, acc};

	assign scan_issue = cmd.scan && (rd_idx_q < cnt_q);
	assign emit_issue = cmd.emit && (rd_idx_q < nwords) && (occ < 2'd2);
	assign issue      = scan_issue | emit_issue;
	assign ram_raddr  = rd_idx_q[AW-1:0];

	// scan: one stored word per cycle compared against the key
	assign scan_data = cmd.scan & pend_q;
	assign hit       = !found_q && (rd_val == key_q);
	assign gt        = !found_q && (rd_val > key_q);
	assign shift_in  = scan_data && ins && !hit && (placed_q || gt);

	assign land      = pend_q & cmd.emit;
	assign land_elem = pend_empty_q ? '0 : rd_val;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pidx_q;
		ram_wdata = carry_q;
		if (scan_data) begin
			if (ins) begin
				// insert: ripple the larger words up by one slot
				ram_we = shift_in && !full;
			end else if (found_q) begin
				// delete: pull the tail down by one slot
				ram_we    = 1'b1;
				ram_waddr = pidx_q - AW'(1);
				ram_wdata = ram_rdata;
			end
		end else if (cmd.fix && ins && !found_q && !full) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			pend_q    <= 1'b0;
			found_q   <= 1'b0;
			placed_q  <= 1'b0;
			dropped_q <= 1'b0;
			out_v_q   <= 1'b0;
			skid_v_q  <= 1'b0;
		end else begin
			pend_q <= issue;
			if (cmd.load || cmd.fix) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (cmd.load) begin
				found_q   <= 1'b0;
				placed_q  <= 1'b0;
				dropped_q <= 1'b0;
			end else begin
				if (scan_data && hit) begin
					found_q <= 1'b1;
				end
				if (shift_in) begin
					placed_q <= 1'b1;
				end
				if (cmd.fix && ins && !found_q && full) begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.fix) begin
				if (ins && !found_q && !full) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (!ins && found_q) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			// output register with skid stage behind it
			if (acc || !out_v_q) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= land;
				end else begin
					out_v_q <= land;
				end
			end else if (land) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			key_q   <= value;
			carry_q <= value;
		end else if (shift_in) begin
			carry_q <= rd_val;
		end
		if (issue) begin
			pidx_q       <= ram_raddr;
			pend_last_q  <= (rd_idx_q == CW'(nwords - CW'(1)));
			pend_empty_q <= (cnt_q == '0);
		end
		if (land) begin
			skid_elem_q <= land_elem;
			skid_last_q <= pend_last_q;
		end
		if (acc || !out_v_q) begin
			if (skid_v_q) begin
				out_elem_q <= skid_elem_q;
				out_last_q <= skid_last_q;
			end else if (land) begin
				out_elem_q <= land_elem;
				out_last_q <= pend_last_q;
			end
		end
	end

	assign status.scan_done = (rd_idx_q == cnt_q) && !pend_q;
	assign status.emit_done = acc && out_last_q;

	assign out_valid = out_v_q;
	assign element   = out_elem_q;
	assign last      = out_last_q;
	assign set_empty = (cnt_q == '0);
	assign dropped   = dropped_q;

endmodule

`default_nettype wire

// ===== hdl/sorted_set_insert_delete_unit.sv =====
// Results: after an input word is accepted, the updated set streams out one word per cycle while
// out_ready is high; an empty set yields a single result word with set_empty raised.
// The next input word is taken only after the last result word is accepted; the single RAM read
// port is swept once to update, once to emit.
// Reset: arst_n clears the member count, so the set starts empty; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_set_insert_delete_unit_assert.svh"

module sorted_set_insert_delete_unit import ssid_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// input word: one insert or delete
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     kind,
	input  wire logic signed [DATA_W-1:0] value,
	// result words: the whole set in ascending order
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      element,
	output logic                          set_empty,
	output logic                          last,
	output logic                          dropped
);

	// The controller walks each word through four phases:
	//   idle - take one input word
	//   scan - read every member once, in order, and rewrite the array in place
	//          (an insert ripples the larger members up, a delete pulls them down)
	//   fix  - append the tail slot on insert, adjust the count, flag a full-set drop
	//   emit - stream the updated set out through an output register and skid stage
	cmd_t    cmd;
	status_t status;

	ssid_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	ssid_datapath #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.kind     (kind),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.element  (element),
		.set_empty(set_empty),
		.last     (last),
		.dropped  (dropped)
	);

	// No result word may still be pending when a new input word is taken.
	`SSID_ASSERT_IMP(a_accept_drained, in_valid && in_ready, !out_valid, "results pending")
	// An accepted word always starts the update sweep.
	`SSID_ASSERT_NXT(a_load_scans, cmd.load, cmd.scan, "accepted word did not start the scan")
	// The final result word hands control back for the next input word.
	`SSID_ASSERT_NXT(a_last_idle, out_valid && out_ready && last, in_ready, "not idle after last")
	// An empty set yields exactly one result word.
	`SSID_ASSERT_IMP(a_empty_single, out_valid && set_empty, last, "empty result not last")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ssid_pkg::*;

	localparam int CAPACITY = 32;
	localparam int POOL_SIZE = 48;
	localparam int RANDOM_WORDS = 260;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;
	localparam int REPORT_LIMIT = 100;

	// One result word as the block emits it.
	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic                     set_empty;
		logic                     last;
		logic                     dropped;
	} set_word_t;

	// One row of the directed table. Rows with pinned set, carry the single result
	// word that the row must produce, typed in by hand.
	typedef struct {
		logic                     op;
		logic signed [DATA_W-1:0] operand;
		bit                       pinned;
		logic signed [DATA_W-1:0] pin_element;
		logic                     pin_empty;
	} op_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     kind;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] element;
	logic                     set_empty;
	logic                     last;
	logic                     dropped;

	// Hand-typed expectation that travels with the input word on the wire.
	logic                     row_pinned;
	logic signed [DATA_W-1:0] row_element;
	logic                     row_empty;

	// Accept flag of the last rising edge, read by the sender at the falling edge.
	logic                     word_taken = 1'b0;

	// Mirror of the set, kept in ascending signed order.
	logic signed [DATA_W-1:0] set_members[$];
	// Result words still owed by the block, oldest first.
	set_word_t                owed_words[$];
	op_row_t                  op_rows[$];
	logic signed [DATA_W-1:0] value_pool[POOL_SIZE];

	int                       fail_count = 0;
	int                       burst_left;
	bit                       hold_req;
	bit                       hold_done;

	sorted_set_insert_delete_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.element(element),
		.set_empty(set_empty),
		.last(last),
		.dropped(dropped)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Apply one accepted insert or delete to the mirror and queue the words it owes.
	// A pinned word replaces the computed one; the mirror still advances.
	task automatic apply_word(input logic op, input logic signed [DATA_W-1:0] v,
			input bit pinned, input logic signed [DATA_W-1:0] pin_element,
			input logic pin_empty);
		int        pos;
		bit        found;
		bit        refused;
		set_word_t w;
		pos = 0;
		refused = 1'b0;
		while (pos < set_members.size() && set_members[pos] < v)
			pos++;
		found = (pos < set_members.size()) && (set_members[pos] == v);
		if (op == KIND_INSERT) begin
			// Duplicates leave the set alone, even when it is full.
			if (!found) begin
				if (set_members.size() >= CAPACITY)
					refused = 1'b1;
				else
					set_members.insert(pos, v);
			end
		end else if (found) begin
			set_members.delete(pos);
		end
		if (pinned) begin
			w.element = pin_element;
			w.set_empty = pin_empty;
			w.last = 1'b1;
			w.dropped = 1'b0;
			owed_words.push_back(w);
		end else if (set_members.size() == 0) begin
			// Empty set: one word, zero element, flagged empty.
			w.element = '0;
			w.set_empty = 1'b1;
			w.last = 1'b1;
			w.dropped = refused;
			owed_words.push_back(w);
		end else begin
			for (int i = 0; i < set_members.size(); i++) begin
				w.element = set_members[i];
				w.set_empty = 1'b0;
				w.last = (i == set_members.size() - 1);
				w.dropped = refused;
				owed_words.push_back(w);
			end
		end
	endtask

	// Sample both channels at the rising edge: advance the mirror on every accepted
	// input word and check every accepted result word against the oldest one owed.
	always @(posedge clk) begin : monitor
		set_word_t want;
		word_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				apply_word(kind, value, row_pinned, row_element, row_empty);
			if (out_valid && out_ready) begin
				if (owed_words.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: unexpected word: element %0d empty %b last %b dropped %b",
							$time, element, set_empty, last, dropped);
				end else begin
					want = owed_words.pop_front();
					if (element !== want.element || set_empty !== want.set_empty ||
							last !== want.last || dropped !== want.dropped) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display({"%0t: mismatch: expected element %0d empty %b last %b ",
								"dropped %b, actual element %0d empty %b last %b dropped %b"},
								$time, want.element, want.set_empty, want.last,
								want.dropped, element, set_empty, last, dropped);
					end
				end
			end
		end
	end

	// Receiver: stall on its own pattern, switching between free-running, coin-flip
	// and mostly-stalled stretches. Hold off once for a long stretch on request so the
	// block backs up into its input.
	initial begin : receiver
		int mode;
		int stretch;
		out_ready = 1'b0;
		hold_done = 1'b0;
		mode = 0;
		stretch = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 2);
					stretch = $urandom_range(8, 40);
				end
				stretch--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Sender idling: bursts of random length, with a gap most of the time between them.
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Offer one word at the falling edge and hold it until a rising edge takes it.
	// Return at the falling edge right after the accept.
	task automatic send_word(input logic op, input logic signed [DATA_W-1:0] v,
			input bit pinned, input logic signed [DATA_W-1:0] pin_element,
			input logic pin_empty);
		kind <= op;
		value <= v;
		row_pinned <= pinned;
		row_element <= pin_element;
		row_empty <= pin_empty;
		in_valid <= 1'b1;
		do
			@(negedge clk);
		while (!word_taken);
	endtask

	task automatic add_row(input logic op, input logic signed [DATA_W-1:0] v,
			input bit pinned, input logic signed [DATA_W-1:0] pin_element,
			input logic pin_empty);
		op_row_t r;
		r.op = op;
		r.operand = v;
		r.pinned = pinned;
		r.pin_element = pin_element;
		r.pin_empty = pin_empty;
		op_rows.push_back(r);
	endtask

	localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

	initial begin : stimulus
		bit                       growing;
		int                       full_items;
		logic                     op;
		logic signed [DATA_W-1:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_INSERT;
		value = '0;
		row_pinned = 1'b0;
		row_element = '0;
		row_empty = 1'b0;
		burst_left = 0;
		hold_req = 1'b0;

		// Directed table: empty-set deletes, extremes at both ends, duplicates,
		// deletes at head, middle and tail, and alternating bit patterns.
		add_row(KIND_DELETE, 32'sd5, 1, '0, 1'b1);
		add_row(KIND_INSERT, MOST_NEG, 1, MOST_NEG, 1'b0);
		add_row(KIND_DELETE, MOST_NEG, 1, '0, 1'b1);
		add_row(KIND_INSERT, MOST_POS, 1, MOST_POS, 1'b0);
		add_row(KIND_INSERT, MOST_POS, 1, MOST_POS, 1'b0);
		add_row(KIND_DELETE, 32'sd0, 1, MOST_POS, 1'b0);
		add_row(KIND_INSERT, MOST_NEG, 0, '0, 1'b0);
		add_row(KIND_INSERT, 32'sd0, 0, '0, 1'b0);
		add_row(KIND_INSERT, -32'sd1, 0, '0, 1'b0);
		add_row(KIND_INSERT, 32'sd1, 0, '0, 1'b0);
		add_row(KIND_INSERT, -32'sd1, 0, '0, 1'b0);
		add_row(KIND_DELETE, 32'sd0, 0, '0, 1'b0);
		add_row(KIND_DELETE, MOST_NEG, 0, '0, 1'b0);
		add_row(KIND_DELETE, MOST_POS, 0, '0, 1'b0);
		add_row(KIND_INSERT, 32'sh5555_5555, 0, '0, 1'b0);
		add_row(KIND_INSERT, 32'shaaaa_aaaa, 0, '0, 1'b0);
		add_row(KIND_DELETE, -32'sd1, 0, '0, 1'b0);
		add_row(KIND_DELETE, 32'sd1, 0, '0, 1'b0);
		add_row(KIND_DELETE, 32'sh5555_5555, 1, 32'shaaaa_aaaa, 1'b0);
		add_row(KIND_DELETE, 32'shaaaa_aaaa, 1, '0, 1'b1);

		// Pool larger than the capacity, so a full set still meets new values.
		value_pool[0] = MOST_NEG;
		value_pool[1] = MOST_POS;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		value_pool[4] = 32'sd1;
		for (int k = 5; k < POOL_SIZE; k++)
			value_pool[k] = $urandom;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (op_rows[r]) begin
			pace();
			send_word(op_rows[r].op, op_rows[r].operand, op_rows[r].pinned,
				op_rows[r].pin_element, op_rows[r].pin_empty);
		end

		// Random part: grow the set until full, linger there to hit refused and
		// duplicate inserts, then shrink to empty, and repeat. One word in ten is noise.
		growing = 1'b1;
		full_items = 0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 60)
				hold_req = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				op = 1'($urandom_range(0, 1));
				v = $urandom;
			end else begin
				if (growing)
					op = ($urandom_range(0, 4) != 0) ? KIND_INSERT : KIND_DELETE;
				else
					op = ($urandom_range(0, 4) != 0) ? KIND_DELETE : KIND_INSERT;
				// Half the time aim at a current member: hits deletes and duplicates.
				if (set_members.size() > 0 && $urandom_range(0, 1) == 1)
					v = set_members[$urandom_range(0, set_members.size() - 1)];
				else
					v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			// While the hold-off runs keep offering words back to back.
			if (!(hold_req && hold_done && n < 80))
				pace();
			send_word(op, v, 1'b0, '0, 1'b0);
			if (set_members.size() == CAPACITY) begin
				full_items++;
				if (full_items >= 8) begin
					growing = 1'b0;
					full_items = 0;
				end
			end else if (set_members.size() == 0) begin
				growing = 1'b1;
			end
		end
		in_valid <= 1'b0;

		while (owed_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run (full-set words under heavy stalls).
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
